>>> rtl/core/pbl_pkg.sv
// Package: sizes, command and status codes, shared types and helpers of the bandwidth ledger.
`default_nettype none

package pbl_pkg;

  localparam int NUM_ENTRIES    = 16;
  localparam int NUM_PRIORITIES = 8;
  localparam int BW_BITS        = 40;

  localparam int OP_W   = 3;
  localparam int KEY_W  = 31;
  localparam int PRIO_W = 8;
  localparam int AMT_W  = 40;
  localparam int ST_W   = 2;

  localparam int SLOT_W    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W     = $clog2(NUM_ENTRIES + 1);
  localparam int PCNT_W    = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
  localparam int CTR_DEPTH = NUM_ENTRIES * NUM_PRIORITIES;
  localparam int CA_W      = (CTR_DEPTH > 1) ? $clog2(CTR_DEPTH) : 1;
  localparam int ACC_W     = BW_BITS + 4;

  localparam logic [BW_BITS-1:0] BW_MAX   = '1;
  localparam logic [63:0]        BW_MAX_W = (64'd1 << BW_BITS) - 64'd1;

  localparam logic [OP_W-1:0] OP_SET_BW  = 3'd0;
  localparam logic [OP_W-1:0] OP_ENABLE  = 3'd1;
  localparam logic [OP_W-1:0] OP_DISABLE = 3'd2;
  localparam logic [OP_W-1:0] OP_RESERVE = 3'd3;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd5;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD_PRIO  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_CLEAR,
    S_UPD,
    S_SUM,
    S_FINAL,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [AMT_W-1:0] avail;
    logic             enabled;
  } resp_t;

  typedef struct packed {
    logic               we;
    logic [CA_W-1:0]    waddr;
    logic [BW_BITS-1:0] wdata;
    logic [CA_W-1:0]    raddr;
  } ctr_req_t;

  typedef struct packed {
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
    logic             sub;
  } alu_req_t;

  function automatic logic [BW_BITS-1:0] sat_amount(input logic [AMT_W-1:0] a);
    logic [63:0] e;
    e = 64'(a);
    return (e > BW_MAX_W) ? BW_MAX : BW_BITS'(e);
  endfunction

  function automatic logic [CA_W-1:0] ctr_addr(input logic [SLOT_W-1:0] slot,
                                               input logic [PCNT_W-1:0] p);
    return CA_W'(int'(slot) * NUM_PRIORITIES + int'(p));
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/pbl_alu.sv
// Shared add/subtract unit with saturation and floor for counter and availability math.
`default_nettype none

module pbl_alu import pbl_pkg::*; (
  input  alu_req_t           req,
  output logic [ACC_W-1:0]   raw,
  output logic [BW_BITS-1:0] clamped
);

  always_comb begin
    raw = req.sub ? (req.a - req.b) : (req.a + req.b);
    if (req.sub) begin
      clamped = raw[ACC_W-1] ? '0 : raw[BW_BITS-1:0];
    end else begin
      clamped = (|raw[ACC_W-1:BW_BITS]) ? BW_MAX : raw[BW_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pbl_ctr_ram.sv
// Reserved-bandwidth counter memory: one write port, one registered read port.
`default_nettype none

module pbl_ctr_ram import pbl_pkg::*; (
  input  logic               clk,
  input  ctr_req_t           req,
  output logic [BW_BITS-1:0] rdata
);

  logic [BW_BITS-1:0] mem [CTR_DEPTH];
  logic [BW_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/core/pbl_seq.sv
// Command sequencer: entry table, key scan, counter update and priority prefix sum.
`default_nettype none

module pbl_seq import pbl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    in_op,
  input  logic [KEY_W-1:0]   in_if_index,
  input  logic [PRIO_W-1:0]  in_priority_req,
  input  logic [AMT_W-1:0]   in_amount_bps,
  output logic               resp_valid,
  input  logic               resp_taken,
  output resp_t              resp,
  output ctr_req_t           ctr_req,
  input  logic [BW_BITS-1:0] ctr_rdata
);

  state_t state_r, state_nxt;

  logic [OP_W-1:0]    op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [PRIO_W-1:0]  prio_r, prio_nxt;
  logic [BW_BITS-1:0] amt_r, amt_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic               hit_r, hit_nxt;
  logic [ST_W-1:0]    status_r, status_nxt;
  logic [BW_BITS-1:0] avail_r, avail_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [PCNT_W-1:0]  pcnt_r, pcnt_nxt;

  logic [KEY_W-1:0]   key_a [NUM_ENTRIES];
  logic               en_a  [NUM_ENTRIES];
  logic [BW_BITS-1:0] rsv_a [NUM_ENTRIES];

  logic               key_we, en_we, en_wd, rsv_we;
  logic [BW_BITS-1:0] rsv_wd;
  logic               prio_ok;

  alu_req_t           alu_req;
  logic [ACC_W-1:0]   alu_raw;
  logic [BW_BITS-1:0] alu_clamped;

  pbl_alu u_alu (
    .req     (alu_req),
    .raw     (alu_raw),
    .clamped (alu_clamped)
  );

  assign prio_ok = 32'(prio_r) < NUM_PRIORITIES;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    prio_r   <= prio_nxt;
    amt_r    <= amt_nxt;
    idx_r    <= idx_nxt;
    slot_r   <= slot_nxt;
    hit_r    <= hit_nxt;
    status_r <= status_nxt;
    avail_r  <= avail_nxt;
    acc_r    <= acc_nxt;
    pcnt_r   <= pcnt_nxt;
    if (key_we) begin
      key_a[slot_nxt] <= key_r;
    end
    if (en_we) begin
      en_a[slot_nxt] <= en_wd;
    end
    if (rsv_we) begin
      rsv_a[slot_nxt] <= rsv_wd;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    prio_nxt   = prio_r;
    amt_nxt    = amt_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    slot_nxt   = slot_r;
    hit_nxt    = hit_r;
    status_nxt = status_r;
    avail_nxt  = avail_r;
    acc_nxt    = acc_r;
    pcnt_nxt   = pcnt_r;
    key_we     = 1'b0;
    en_we      = 1'b0;
    en_wd      = 1'b0;
    rsv_we     = 1'b0;
    rsv_wd     = '0;
    ctr_req    = '0;
    alu_req    = '0;
    in_stall   = 1'b1;
    resp_valid = 1'b0;
    resp.status  = status_r;
    resp.avail   = AMT_W'(avail_r);
    resp.enabled = hit_r ? en_a[slot_r] : 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          op_nxt     = in_op;
          key_nxt    = in_if_index;
          prio_nxt   = in_priority_req;
          amt_nxt    = sat_amount(in_amount_bps);
          idx_nxt    = '0;
          hit_nxt    = 1'b0;
          status_nxt = ST_OK;
          avail_nxt  = '0;
          state_nxt  = S_SCAN;
        end
      end

      S_SCAN: begin
        if (idx_r == count_r) begin
          state_nxt = S_DECIDE;
        end else if (key_a[idx_r[SLOT_W-1:0]] == key_r) begin
          hit_nxt   = 1'b1;
          slot_nxt  = idx_r[SLOT_W-1:0];
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      S_DECIDE: begin
        state_nxt = S_RESP;
        unique case (op_r)
          OP_SET_BW, OP_ENABLE: begin
            if (hit_r) begin
              en_we  = (op_r == OP_ENABLE);
              en_wd  = 1'b1;
              rsv_we = (op_r == OP_SET_BW);
              rsv_wd = amt_r;
            end else if (32'(count_r) == NUM_ENTRIES) begin
              status_nxt = ST_FULL;
            end else begin
              slot_nxt  = count_r[SLOT_W-1:0];
              hit_nxt   = 1'b1;
              count_nxt = count_r + CNT_W'(1);
              key_we    = 1'b1;
              en_we     = 1'b1;
              en_wd     = (op_r == OP_ENABLE);
              rsv_we    = 1'b1;
              rsv_wd    = (op_r == OP_SET_BW) ? amt_r : '0;
              pcnt_nxt  = '0;
              state_nxt = S_CLEAR;
            end
          end
          OP_DISABLE: begin
            if (hit_r) begin
              en_we = 1'b1;
              en_wd = 1'b0;
            end else begin
              status_nxt = ST_NOT_FOUND;
            end
          end
          OP_RESERVE, OP_RELEASE, OP_QUERY: begin
            if (!prio_ok) begin
              status_nxt = ST_BAD_PRIO;
            end else if (!hit_r) begin
              status_nxt = ST_NOT_FOUND;
            end else if (op_r == OP_QUERY) begin
              ctr_req.raddr = ctr_addr(slot_r, '0);
              pcnt_nxt      = '0;
              acc_nxt       = '0;
              state_nxt     = S_SUM;
            end else begin
              ctr_req.raddr = ctr_addr(slot_r, prio_r[PCNT_W-1:0]);
              state_nxt     = S_UPD;
            end
          end
          default: begin
            status_nxt = ST_OK;
          end
        endcase
      end

      S_CLEAR: begin
        ctr_req.we    = 1'b1;
        ctr_req.waddr = ctr_addr(slot_r, pcnt_r);
        ctr_req.wdata = '0;
        if (pcnt_r == PCNT_W'(NUM_PRIORITIES - 1)) begin
          state_nxt = S_RESP;
        end else begin
          pcnt_nxt = pcnt_r + PCNT_W'(1);
        end
      end

      S_UPD: begin
        alu_req.a     = ACC_W'(ctr_rdata);
        alu_req.b     = ACC_W'(amt_r);
        alu_req.sub   = (op_r == OP_RELEASE);
        ctr_req.we    = 1'b1;
        ctr_req.waddr = ctr_addr(slot_r, prio_r[PCNT_W-1:0]);
        ctr_req.wdata = alu_clamped;
        state_nxt     = S_RESP;
      end

      S_SUM: begin
        alu_req.a   = acc_r;
        alu_req.b   = ACC_W'(ctr_rdata);
        alu_req.sub = 1'b0;
        acc_nxt     = alu_raw;
        if (PRIO_W'(pcnt_r) == prio_r) begin
          state_nxt = S_FINAL;
        end else begin
          pcnt_nxt      = pcnt_r + PCNT_W'(1);
          ctr_req.raddr = ctr_addr(slot_r, pcnt_r + PCNT_W'(1));
        end
      end

      S_FINAL: begin
        alu_req.a   = ACC_W'(rsv_a[slot_r]);
        alu_req.b   = acc_r;
        alu_req.sub = 1'b1;
        avail_nxt   = alu_clamped;
        state_nxt   = S_RESP;
      end

      S_RESP: begin
        resp_valid = 1'b1;
        if (resp_taken) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= NUM_ENTRIES)
    else $error("entry count above table size");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && !in_stall) |=> (state_r == S_SCAN))
    else $error("accepted word did not start a scan");

  a_ctr_write: assert property (@(posedge clk) disable iff (!rst_n)
    ctr_req.we |-> (state_r == S_CLEAR || state_r == S_UPD))
    else $error("counter write outside clear or update");
`endif

endmodule

`default_nettype wire

>>> rtl/core/priority_bandwidth_ledger_core.sv
// Top level of the priority bandwidth ledger: sequencer, counter memory and result register.
//
// Input channel in_*: one command word (op, if_index, priority_req, amount_bps) is taken
// when in_valid is high and in_stall is low. The core works on one word at a time and
// holds in_stall high until that word's result has moved into the output register.
// Result channel out_*: one word (status, available_bps, is_enabled) per command,
// taken when out_valid is high and out_stall is low.
// Steps from input accept to the result in the output register: a key scan that ends
//   at a hit or at the entry count (one key compare a cycle), a decide step, then a
//   clear of all NUM_PRIORITIES counters of a newly created entry, a counter read and
//   update for reserve/release, or for query one counter memory read per summed priority
//   (0 .. priority_req) and a subtraction of the sum from the entry's reserved bandwidth;
//   the other cases (disable, bad priority, not found, table full) add no further step.
// The output register lets the next command be accepted while a result is stalled;
// a stalled result holds until taken, and the core then waits in its result state.
// Synchronous reset empties the table (entry count zero) and drops out_valid; no
// memory clearing pass is needed, since each counter row is cleared when created.
`default_nettype none

module priority_bandwidth_ledger_core import pbl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_op,
  input  logic [KEY_W-1:0]  in_if_index,
  input  logic [PRIO_W-1:0] in_priority_req,
  input  logic [AMT_W-1:0]  in_amount_bps,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ST_W-1:0]   out_status,
  output logic [AMT_W-1:0]  out_available_bps,
  output logic              out_is_enabled
);

  resp_t              resp;
  logic               resp_valid;
  logic               resp_taken;
  ctr_req_t           ctr_req;
  logic [BW_BITS-1:0] ctr_rdata;

  logic  out_valid_r, out_valid_nxt;
  resp_t out_r;

  pbl_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_if_index     (in_if_index),
    .in_priority_req (in_priority_req),
    .in_amount_bps   (in_amount_bps),
    .resp_valid      (resp_valid),
    .resp_taken      (resp_taken),
    .resp            (resp),
    .ctr_req         (ctr_req),
    .ctr_rdata       (ctr_rdata)
  );

  pbl_ctr_ram u_ctr_ram (
    .clk   (clk),
    .req   (ctr_req),
    .rdata (ctr_rdata)
  );

  assign resp_taken = resp_valid && (!out_valid_r || !out_stall);

  always_comb begin
    if (resp_taken) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_taken) begin
      out_r <= resp;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_available_bps = out_r.avail;
  assign out_is_enabled    = out_r.enabled;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    resp_taken |-> (!out_valid_r || !out_stall))
    else $error("result word overwrote a pending output");

  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    resp_taken |=> !resp_taken)
    else $error("one command gave two result words");

  a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !resp_valid)
    else $error("input accepted while a result is pending in the core");
`endif

endmodule

`default_nettype wire
